[design/tsi_pkg.sv]
// Shared types and constants for the table sample interpolator.
// Standalone: depends on nothing.
package tsi_pkg;
	localparam logic [1:0] KIND_LINEAR  = 2'd0;
	localparam logic [1:0] KIND_CUBIC   = 2'd1;
	localparam logic [1:0] KIND_HERMITE = 2'd2;
	localparam logic [1:0] KIND_INVALID = 2'd3;

	localparam logic [1:0] REG_LENGTH  = 2'd0;
	localparam logic [1:0] REG_WRAP    = 2'd1;
	localparam logic [1:0] REG_TENSION = 2'd2;
	localparam logic [1:0] REG_BIAS    = 2'd3;

	localparam int ACC_W = 56;
	localparam int FRAC_W = 16;

	typedef logic signed [ACC_W-1:0] acc_t;
endpackage

[design/tsi_serial_mul.sv]
// Bit-serial signed by unsigned multiplier: one fraction bit per cycle.
// Depends on tsi_pkg for the accumulator type.
module tsi_serial_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  tsi_pkg::acc_t      a,
	input  logic [15:0]        f,
	output logic               done,
	output tsi_pkg::acc_t      p
);
	import tsi_pkg::*;

	logic [15:0] f_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	acc_t        a_q;
	acc_t        acc_q;
	acc_t        acc_n;

	// Shift-right add: after 16 steps acc holds floor(a*f / 2^16).
	always_comb begin
		acc_n = acc_q;
		if (f_q[0]) begin
			acc_n = acc_q + a_q;
		end
		acc_n = acc_n >>> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd15) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q   <= a;
			f_q   <= f;
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_n;
			f_q   <= {1'b0, f_q[15:1]};
		end
	end

	assign p = acc_q;

	assert property (@(posedge clk) disable iff (!arst_n) !(go && run_q))
		else $error("multiplier restarted while running");
	assert property (@(posedge clk) disable iff (!arst_n) !(done && run_q))
		else $error("done raised while running");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(run_q))
		else $error("done without a run");
endmodule

[design/table_sample_interpolator_unit.sv]
// Top level of the table sample interpolator: table memory, neighbour gather,
// coefficient setup and a Horner sequencer over tsi_serial_mul. Uses tsi_pkg.
//
// Channel   | Direction | Handshake          | Words
// ----------+-----------+--------------------+-------------------------------------
// command   | in        | start & !busy      | mode, entry_index, sample_value, ...
// result    | out       | result_valid pulse | result_value, bad_request
// config    | in        | cfg_write          | cfg_index, cfg_data
//
// A write word lands in the table at the accepting edge. A query gathers the four
// neighbours through the single memory read port (address, then data), then
// runs its Horner steps in the bit-serial multiplier; hermite first adds two
// slope products. A bad word skips the gather and goes straight to its strobe.
// Reset clears control state and configuration; the table stays undefined until
// written. The receiver cannot stall: result_valid is high for one cycle only.
module table_sample_interpolator_unit #(
	parameter int TABLE_DEPTH  = 1024,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           mode,
	input  logic [9:0]                     entry_index,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_value,
	input  logic [15:0]                    fraction,
	input  logic [1:0]                     kind,
	output logic                           result_valid,
	output logic signed [SAMPLE_WIDTH-1:0] result_value,
	output logic                           bad_request,
	input  logic                           cfg_write,
	input  logic [1:0]                     cfg_index,
	input  logic [15:0]                    cfg_data
);
	import tsi_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int LW = AW + 1;
	localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_WT   = 4'd2;
	localparam logic [3:0] ST_SL0  = 4'd3;
	localparam logic [3:0] ST_SL1  = 4'd4;
	localparam logic [3:0] ST_COEF = 4'd5;
	localparam logic [3:0] ST_MUL  = 4'd6;
	localparam logic [3:0] ST_MWT  = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;
	localparam logic [3:0] ST_BAD  = 4'd9;

	logic [10:0] length_q;
	logic        wrap_q;
	logic signed [15:0] tension_q, bias_q;

	logic signed [SAMPLE_WIDTH-1:0] mem [TABLE_DEPTH];
	logic signed [SAMPLE_WIDTH-1:0] rd_q;
	logic [AW-1:0] rd_addr;

	logic [3:0]  state_q;
	logic [1:0]  nb_q;      // neighbour being fetched: 0..3 = y0..y3
	logic [2:0]  step_q;
	logic [1:0]  kind_q;
	logic [15:0] f_q;
	logic [LW-1:0] idx_q, len_q;
	logic signed [SAMPLE_WIDTH-1:0] y_q [4];
	acc_t c_q [3];
	acc_t h_q;
	acc_t m0_q, m1_q;

	logic mul_go, mul_done;
	logic [15:0] mul_f;
	acc_t mul_a, mul_p;

	// Effective length, clamped to [3, TABLE_DEPTH].
	logic [LW-1:0] len_eff;
	always_comb begin
		if (length_q < 11'd3) begin
			len_eff = LW'(3);
		end else if (32'(length_q) > TABLE_DEPTH) begin
			len_eff = DEPTH_L;
		end else begin
			len_eff = LW'(length_q);
		end
	end

	// Neighbour address: base + nb - 1, clamped or wrapped.
	logic signed [LW+1:0] n_raw;
	logic [LW-1:0] n_sel;
	always_comb begin
		n_raw = $signed({2'b00, idx_q}) + $signed({{LW{1'b0}}, nb_q}) - (LW+2)'(1);
		if (wrap_q) begin
			if (n_raw < 0) begin
				n_sel = LW'(n_raw + $signed({2'b00, len_q}));
			end else if (n_raw >= $signed({2'b00, len_q})) begin
				n_sel = LW'(n_raw - $signed({2'b00, len_q}));
			end else begin
				n_sel = LW'(n_raw);
			end
		end else begin
			if (n_raw < 0) begin
				n_sel = '0;
			end else if (n_raw >= $signed({2'b00, len_q})) begin
				n_sel = len_q - LW'(1);
			end else begin
				n_sel = LW'(n_raw);
			end
		end
	end

	assign rd_addr = (state_q == ST_IDLE) ? AW'(entry_index) : n_sel[AW-1:0];

	// Table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (start && !busy && !mode && 32'(entry_index) < TABLE_DEPTH) begin
			mem[AW'(entry_index)] <= sample_value;
		end
		rd_q <= mem[rd_addr];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q  <= 11'd1024;
			wrap_q    <= 1'b0;
			tension_q <= -16'sd4096;
			bias_q    <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_LENGTH:  length_q  <= cfg_data[10:0];
				REG_WRAP:    wrap_q    <= cfg_data[0];
				REG_TENSION: tension_q <= cfg_data;
				REG_BIAS:    bias_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Slope setup: m = floor(((da(1+b) + db(1-b))(1-t)) / 2^13).
	// The two bias products are narrow (17 by 18 bits); (1-t) goes serial.
	acc_t d10, d21, d32;
	logic signed [16:0] sl_da, sl_db;
	logic signed [17:0] opb, omb, omt;
	logic signed [34:0] sl_pa, sl_pb;
	logic signed [35:0] sl_sum;
	logic               omt_neg;
	assign d10 = acc_t'(y_q[1]) - acc_t'(y_q[0]);
	assign d21 = acc_t'(y_q[2]) - acc_t'(y_q[1]);
	assign d32 = acc_t'(y_q[3]) - acc_t'(y_q[2]);
	assign opb = 18'sd16384 + 18'(bias_q);
	assign omb = 18'sd16384 - 18'(bias_q);
	assign omt = 18'sd16384 - 18'(tension_q);
	assign omt_neg = omt[17];
	assign sl_da = (state_q == ST_SL0) ? 17'(y_q[1]) - 17'(y_q[0])
		: 17'(y_q[2]) - 17'(y_q[1]);
	assign sl_db = (state_q == ST_SL0) ? 17'(y_q[2]) - 17'(y_q[1])
		: 17'(y_q[3]) - 17'(y_q[2]);
	assign sl_pa = 35'(sl_da) * 35'(opb);
	assign sl_pb = 35'(sl_db) * 35'(omb);
	assign sl_sum = 36'(sl_pa) + 36'(sl_pb);

	// Slope times (1-t) via the serial multiplier. Pass sum*2^3 with fraction
	// |1-t| (below 2^16), so floor/2^16 gives floor/2^13. When (1-t) is
	// negative, negate both factors: the product and its floor are unchanged.
	logic mul_for_slope;

	always_comb begin
		mul_go = 1'b0;
		mul_a  = h_q;
		mul_f  = f_q;
		if (state_q == ST_SL0 || state_q == ST_SL1) begin
			mul_go = !mul_for_slope;
			mul_a  = omt_neg ? -(acc_t'(sl_sum) <<< 3) : (acc_t'(sl_sum) <<< 3);
			mul_f  = omt_neg ? 16'(-omt) : omt[15:0];
		end else if (state_q == ST_MUL) begin
			mul_go = 1'b1;
		end
	end

	tsi_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.a      (mul_a),
		.f      (mul_f),
		.done   (mul_done),
		.p      (mul_p)
	);

	// Final rounding to nearest, ties up, then saturate.
	acc_t rnd;
	logic signed [SAMPLE_WIDTH-1:0] sat;
	localparam acc_t SMAX = acc_t'((64'sd1 <<< (SAMPLE_WIDTH-1)) - 1);
	localparam acc_t SMIN = -acc_t'(64'sd1 <<< (SAMPLE_WIDTH-1));
	assign rnd = (h_q + acc_t'(32768)) >>> FRAC_W;
	always_comb begin
		if (rnd > SMAX) begin
			sat = SMAX[SAMPLE_WIDTH-1:0];
		end else if (rnd < SMIN) begin
			sat = SMIN[SAMPLE_WIDTH-1:0];
		end else begin
			sat = rnd[SAMPLE_WIDTH-1:0];
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			result_valid  <= 1'b0;
			nb_q          <= '0;
			step_q        <= '0;
			mul_for_slope <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start && mode) begin
						if (kind == KIND_INVALID || 32'(entry_index) >= 32'(len_eff)) begin
							state_q <= ST_BAD;
						end else begin
							state_q <= ST_RD;
							nb_q    <= '0;
						end
					end
				end
				ST_RD: begin
					// address for nb_q presented; data arrives next cycle
					state_q <= ST_WT;
				end
				ST_WT: begin
					nb_q <= nb_q + 2'd1;
					if (nb_q == 2'd3) begin
						state_q <= (kind_q == KIND_HERMITE) ? ST_SL0 : ST_COEF;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_SL0, ST_SL1: begin
					if (!mul_for_slope) begin
						mul_for_slope <= 1'b1;
					end else if (mul_done) begin
						mul_for_slope <= 1'b0;
						state_q <= (state_q == ST_SL0) ? ST_SL1 : ST_COEF;
					end
				end
				ST_COEF: begin
					step_q  <= '0;
					state_q <= (kind_q == KIND_LINEAR) ? ST_MUL : ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_MWT;
				end
				ST_MWT: begin
					if (mul_done) begin
						step_q <= step_q + 3'd1;
						if (kind_q == KIND_LINEAR || step_q == 3'd2) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_OUT: begin
					result_valid <= 1'b1;
					state_q      <= ST_IDLE;
				end
				ST_BAD: begin
					result_valid <= 1'b1;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kind_q <= kind;
				f_q    <= fraction;
				idx_q  <= LW'(entry_index);
				len_q  <= len_eff;
			end
			ST_WT: y_q[nb_q] <= rd_q;
			ST_SL0, ST_SL1: begin
				if (mul_for_slope && mul_done) begin
					if (state_q == ST_SL0) begin
						m0_q <= mul_p;
					end else begin
						m1_q <= mul_p;
					end
				end
			end
			ST_COEF: begin
				// Load the leading coefficient; later ones are added in order.
				if (kind_q == KIND_LINEAR) begin
					h_q    <= d21 <<< FRAC_W;
					c_q[0] <= acc_t'(y_q[1]) <<< FRAC_W;
				end else if (kind_q == KIND_CUBIC) begin
					h_q    <= (d32 + d10) <<< FRAC_W;
					c_q[2] <= (acc_t'(y_q[0]) - acc_t'(y_q[1]) - d32 - d10) <<< FRAC_W;
					c_q[1] <= (acc_t'(y_q[2]) - acc_t'(y_q[0])) <<< FRAC_W;
					c_q[0] <= acc_t'(y_q[1]) <<< FRAC_W;
				end else begin
					h_q    <= ((-d21) <<< (FRAC_W+1)) + m0_q + m1_q;
					c_q[2] <= ((d21 + (d21 <<< 1)) <<< FRAC_W) - (m0_q <<< 1) - m1_q;
					c_q[1] <= m0_q;
					c_q[0] <= acc_t'(y_q[1]) <<< FRAC_W;
				end
			end
			ST_MWT: begin
				if (mul_done) begin
					if (kind_q == KIND_LINEAR || step_q == 3'd2) begin
						h_q <= mul_p + c_q[0];
					end else if (step_q == 3'd0) begin
						h_q <= mul_p + c_q[2];
					end else begin
						h_q <= mul_p + c_q[1];
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT) begin
			result_value <= sat;
			bad_request  <= 1'b0;
		end else if (state_q == ST_BAD) begin
			result_value <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
			bad_request  <= 1'b1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) result_valid |=> !result_valid)
		else $error("two results back to back");
	assert property (@(posedge clk) disable iff (!arst_n) result_valid |-> !busy)
		else $error("result while still busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == ST_MWT && kind_q == KIND_LINEAR && step_q > 3'd0))
		else $error("linear ran past one step");
endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for table_sample_interpolator_unit: table writes and
// linear, cubic and hermite queries checked against a behavioural predictor.
// Depends on tsi_pkg and the design top level only.
module tb;
	import tsi_pkg::*;

	// Predicts every query result and checks the results the block emits,
	// oldest first.
	class interp_scoreboard;
		int unsigned n_err;
		shortint     tbl [1024];
		int          len_reg;
		bit          wrap;
		longint      ten;
		longint      bia;
		logic signed [15:0] exp_val [$];
		logic               exp_bad [$];

		function new();
			n_err = 0;
			len_reg = 1024;
			wrap = 0;
			ten = -4096;
			bia = 0;
			foreach (tbl[i]) tbl[i] = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] d);
			case (idx)
				REG_LENGTH:  len_reg = d[10:0];
				REG_WRAP:    wrap = d[0];
				REG_TENSION: ten = longint'($signed(d));
				REG_BIAS:    bia = longint'($signed(d));
				default: ;
			endcase
		endfunction

		function int eff_len();
			if (len_reg < 3) return 3;
			if (len_reg > 1024) return 1024;
			return len_reg;
		endfunction

		// Entry that the block reads as neighbour base+d
		function int gather(int base, int d);
			int n;
			int l;
			l = eff_len();
			n = base + d;
			if (wrap) return (n + l) % l;
			if (n < 0) return 0;
			if (n > l - 1) return l - 1;
			return n;
		endfunction

		// Hermite slope with 16 extra fraction bits, floor rounded
		function longint tilt(longint da, longint db);
			return ((da * (16384 + bia) + db * (16384 - bia)) * (16384 - ten)) >>> 13;
		endfunction

		function longint horner(longint c3, longint c2, longint c1, longint c0, longint f);
			longint h;
			h = c3;
			h = ((h * f) >>> 16) + c2;
			h = ((h * f) >>> 16) + c1;
			h = ((h * f) >>> 16) + c0;
			return (h + 32768) >>> 16;
		endfunction

		function void note_word(logic md, logic [9:0] idx, logic [15:0] sv,
				logic [15:0] frac, logic [1:0] knd);
			longint y0, y1, y2, y3, r, f, a0, a1, a2, m0, m1;
			int i;
			i = idx;
			if (!md) begin
				tbl[i] = $signed(sv);
				return;
			end
			f = frac;
			if (knd == KIND_INVALID || i >= eff_len()) begin
				exp_val.push_back(16'sh8000);
				exp_bad.push_back(1'b1);
				return;
			end
			y1 = tbl[i];
			y0 = tbl[gather(i, -1)];
			y2 = tbl[gather(i, 1)];
			y3 = tbl[gather(i, 2)];
			case (knd)
				KIND_LINEAR: r = ((y1 <<< 16) + (y2 - y1) * f + 32768) >>> 16;
				KIND_CUBIC: begin
					a0 = y3 - y2 - y0 + y1;
					a1 = y0 - y1 - a0;
					a2 = y2 - y0;
					r = horner(a0 <<< 16, a1 <<< 16, a2 <<< 16, y1 <<< 16, f);
				end
				default: begin
					m0 = tilt(y1 - y0, y2 - y1);
					m1 = tilt(y2 - y1, y3 - y2);
					r = horner(2 * (y1 - y2) * 65536 + m0 + m1,
						3 * (y2 - y1) * 65536 - 2 * m0 - m1, m0, y1 <<< 16, f);
				end
			endcase
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			exp_val.push_back(r[15:0]);
			exp_bad.push_back(1'b0);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			n_err++;
		endtask

		task check_result(logic signed [15:0] v, logic b);
			logic signed [15:0] ev;
			logic               eb;
			if (exp_val.size() == 0) begin
				report($sformatf("unexpected result value %0d bad %0b", v, b));
				return;
			end
			ev = exp_val.pop_front();
			eb = exp_bad.pop_front();
			if (v !== ev)
				report($sformatf("result_value %0d, expected %0d", v, ev));
			if (b !== eb)
				report($sformatf("bad_request %0b, expected %0b", b, eb));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               mode;
	logic [9:0]         entry_index;
	logic signed [15:0] sample_value;
	logic [15:0]        fraction;
	logic [1:0]         kind;
	logic               result_valid;
	logic signed [15:0] result_value;
	logic               bad_request;
	logic               cfg_write;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;

	interp_scoreboard sb = new();
	bit  written [1024];
	int  words_sent;

	table_sample_interpolator_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .entry_index(entry_index), .sample_value(sample_value),
		.fraction(fraction), .kind(kind), .result_valid(result_valid),
		.result_value(result_value), .bad_request(bad_request),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Generous ceiling: far beyond the slowest legal run of every phase.
	initial begin
		#30ms;
		$display("FAILED: results differ");
		$finish;
	end

	// Results cannot be held off: check every strobe on the edge that ends it.
	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result(result_value, bad_request);
	end

	// Sample with a fair share of full-scale values so every bit toggles.
	function logic [15:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Drive one word and hold it until accepted. The sender idles first in
	// 23 of a hundred words, then in 48, then not at all.
	task send_word(logic md, logic [9:0] idx, logic [15:0] sv, logic [15:0] frac,
			logic [1:0] knd);
		int pct;
		pct = (words_sent < 433) ? 23 : (words_sent < 866) ? 48 : 0;
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		start <= 1'b1;
		mode <= md;
		entry_index <= idx;
		sample_value <= sv;
		fraction <= frac;
		kind <= knd;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_word(md, idx, sv, frac, knd);
		if (!md) written[idx] = 1'b1;
		words_sent++;
	endtask

	// Issue a query, unless a neighbour the block would gather has never been
	// written: then write that neighbour instead, as reading such an entry is out of contract.
	task ask(logic [9:0] idx, logic [15:0] frac, logic [1:0] knd);
		int n;
		if (idx < sb.eff_len()) begin
			for (int d = -1; d <= 2; d++) begin
				n = sb.gather(idx, d);
				if (!written[n]) begin
					send_word(1'b0, n[9:0], pick_sample(), 16'($urandom), 2'($urandom));
					return;
				end
			end
		end
		send_word(1'b1, idx, 16'($urandom), frac, knd);
	endtask

	// Drop start and wait for every outstanding result, then let the block
	// settle after a trailing write.
	task drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.exp_val.size() != 0 || busy) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// Write all four registers on consecutive edges; the block is idle.
	task configure(logic [15:0] len, logic [15:0] wr, logic [15:0] ten, logic [15:0] bia);
		logic [15:0] vals [4];
		vals = '{len, wr, ten, bia};
		for (int i = 0; i < 4; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= i[1:0];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_reg(i[1:0], vals[i]);
		end
		cfg_write <= 1'b0;
	endtask

	task random_words(int count);
		int l;
		logic [9:0] idx;
		for (int i = 0; i < count; i++) begin
			l = sb.eff_len();
			// Mostly in range so queries get past the gather; sometimes anywhere.
			idx = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(l - 1));
			if ($urandom_range(3) == 0)
				send_word(1'b0, idx, pick_sample(), 16'($urandom), 2'($urandom));
			else
				ask(idx, ($urandom_range(9) == 0) ? 16'hffff : 16'($urandom),
					2'($urandom_range(3)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = 1'b0;
		entry_index = '0;
		sample_value = '0;
		fraction = '0;
		kind = KIND_LINEAR;
		cfg_write = 1'b0;
		cfg_index = REG_LENGTH;
		cfg_data = '0;
		words_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: full-scale alternating samples, clamped ends, every kind,
		// fraction extremes and an invalid kind, under the reset settings.
		send_word(1'b0, 10'd0, 16'h7fff, 16'h0, KIND_LINEAR);
		send_word(1'b0, 10'd1, 16'h8000, 16'hffff, KIND_CUBIC);
		send_word(1'b0, 10'd2, 16'h7fff, 16'h0, KIND_HERMITE);
		send_word(1'b0, 10'd3, 16'h8000, 16'h0, KIND_INVALID);
		send_word(1'b0, 10'd4, 16'h0000, 16'h0, KIND_LINEAR);
		send_word(1'b0, 10'd1022, 16'h8000, 16'h0, KIND_LINEAR);
		send_word(1'b0, 10'd1023, 16'h7fff, 16'h0, KIND_LINEAR);
		ask(10'd0, 16'hffff, KIND_LINEAR);
		ask(10'd0, 16'h8000, KIND_CUBIC);
		ask(10'd1, 16'hffff, KIND_CUBIC);
		ask(10'd1, 16'hffff, KIND_HERMITE);
		ask(10'd2, 16'h0000, KIND_HERMITE);
		ask(10'd2, 16'h8000, KIND_CUBIC);
		ask(10'd1, 16'h0000, KIND_LINEAR);
		ask(10'd1022, 16'hffff, KIND_LINEAR);
		ask(10'd1022, 16'h4000, KIND_CUBIC);
		ask(10'd1022, 16'hc000, KIND_HERMITE);
		ask(10'd1023, 16'hffff, KIND_CUBIC);
		ask(10'd3, 16'h1234, KIND_INVALID);
		random_words(160);
		// Pause until every expected result has come before reconfiguring.
		drain();

		// Shortest table, wrapping, tension and bias at opposite extremes.
		configure(16'd3, 16'd1, 16'sd16384, -16'sd16384);
		random_words(180);
		drain();
		// Length below the floor acts as three; clamp; reversed extremes.
		configure(16'd2, 16'd0, -16'sd16384, 16'sd16384);
		random_words(180);
		drain();
		configure(16'd20, 16'd1, 16'sd0, 16'sd4000);
		random_words(180);
		drain();
		// Length above the depth acts as the full table.
		configure(16'd2047, 16'd0, -16'sd4096, 16'sd0);
		random_words(180);
		drain();
		configure(16'd0, 16'd1, 16'($urandom_range(32768) - 16384),
			16'($urandom_range(32768) - 16384));
		random_words(180);
		drain();
		configure(16'd1024, 16'd1, 16'($urandom_range(32768) - 16384),
			16'($urandom_range(32768) - 16384));
		random_words(180);
		drain();

		if (sb.n_err == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
